/* src/ptbc_pkg.sv */
// Shared types for the packed tree branch counter.
`timescale 1ns / 1ps
package ptbc_pkg;

  // Branch size after reset and the smallest branch size that is used.
  localparam logic [7:0] BRANCH_SIZE_RESET = 8'd10;
  localparam logic [7:0] BRANCH_SIZE_MIN   = 8'd2;

  // Controller states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_Q_START,
    ST_Q_WAIT,
    ST_SQ_START,
    ST_SQ_WAIT,
    ST_CAP_START,
    ST_CAP_WAIT,
    ST_FULL_START,
    ST_FULL_WAIT,
    ST_C1_START,
    ST_C1_WAIT,
    ST_C2_START,
    ST_C2_WAIT,
    ST_MUL_START,
    ST_MUL_WAIT,
    ST_ACC,
    ST_DONE
  } state_t;

  // Which division the shared divider is working on.
  typedef enum logic [2:0] {
    DIV_Q,     // ceil(n / b)
    DIV_CAP,   // ceil(n / slices)
    DIV_FULL,  // n div cap and n mod cap
    DIV_C1,    // ceil(cap / b)
    DIV_C2     // ceil(rem / b)
  } div_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     sqrt_start;
    logic     mul_start;
    logic     acc;
    logic     out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic mul_done;
    logic n_gt1;
    logic stop;
    logic out_free;
  } sts_t;

endpackage

/* src/ptbc_div.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ptbc_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem
);

  localparam int CW = $clog2(W + 1);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [W:0]    trial;
  logic          fits;

  // One restoring step: bring down the next dividend bit and try to subtract.
  assign trial = {rem_r, quo_r[W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - 1'b1;
        quo_nxt = {quo_r[W-2:0], fits};
        rem_nxt = fits ? W'(trial - {1'b0, dvs_r}) : trial[W-1:0];
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = busy_r && (cnt_r == '0);
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

/* src/ptbc_sqrt.sv */
// Digit-by-digit integer square root, rounded up, two radicand bits per cycle.
`timescale 1ns / 1ps
module ptbc_sqrt #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] radicand,
  output logic         done,
  output logic [W-1:0] root_ceil
);

  localparam int SW = W + (W % 2);
  localparam int H  = SW / 2;
  localparam int CW = $clog2(H + 1);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] rad_r, rad_nxt;
  logic [H-1:0]  root_r, root_nxt;
  logic [H+1:0]  rem_r, rem_nxt;
  logic [H+3:0]  rem_sh;
  logic [H+3:0]  trial;
  logic          fits;

  // Bring down two bits and try root*4+1.
  assign rem_sh = {rem_r, rad_r[SW-1:SW-2]};
  assign trial  = (H + 4)'({root_r, 2'b01});
  assign fits   = (rem_sh >= trial);

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    root_nxt = root_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(H);
      rad_nxt  = SW'(radicand);
      root_nxt = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_nxt  = cnt_r - 1'b1;
        rad_nxt  = {rad_r[SW-3:0], 2'b00};
        root_nxt = {root_r[H-2:0], fits};
        rem_nxt  = fits ? (H + 2)'(rem_sh - trial) : rem_sh[H+1:0];
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
  end

  // A nonzero remainder means the floor root is one short of the ceiling.
  assign done      = busy_r && (cnt_r == '0);
  assign root_ceil = W'(root_r) + W'(rem_r != '0);

endmodule

/* src/ptbc_dp.sv */
// Datapath: level registers, shared divider, square root, multiplier, total and output register.
`timescale 1ns / 1ps
module ptbc_dp #(
  parameter int W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_wr_data,
  input  logic [31:0]      leaf_count,
  input  ptbc_pkg::cmd_t   cmd,
  output ptbc_pkg::sts_t   sts,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [W:0]       out_total
);

  import ptbc_pkg::*;

  localparam int         SUM_W     = W + 3;
  localparam logic [W:0] TOTAL_MAX = '1;

  logic [7:0]     bsize_r;
  logic [7:0]     b_eff;
  logic [W-1:0]   n_r, q_r, s_r, cap_r, full_r, rem_r, c1_r, c2_r;
  logic [W+1:0]   prod_r, mul_a_r;
  logic [W-1:0]   mul_b_r;
  logic           mul_busy_r;
  logic [W:0]     total_r;
  logic           out_valid_r;
  logic [W:0]     out_data_r;
  div_sel_t       div_sel_r;

  logic [W-1:0]   div_a, div_d, div_quo, div_rem, div_ceil;
  logic           div_done;
  logic [W-1:0]   sq_root;
  logic           sq_done;
  logic           mul_done;
  logic [SUM_W-1:0] parents, sum;
  logic           sat;

  // Branch size register; values below two count as two.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsize_r <= BRANCH_SIZE_RESET;
    end else if (cfg_wr_en) begin
      bsize_r <= cfg_wr_data;
    end
  end
  assign b_eff = (bsize_r < BRANCH_SIZE_MIN) ? BRANCH_SIZE_MIN : bsize_r;

  // Operand selection for the shared divider.
  always_comb begin
    div_a = n_r;
    div_d = W'(b_eff);
    unique case (cmd.div_sel)
      DIV_Q: begin
        div_a = n_r;
        div_d = W'(b_eff);
      end
      DIV_CAP: begin
        div_a = n_r;
        div_d = s_r;
      end
      DIV_FULL: begin
        div_a = n_r;
        div_d = cap_r;
      end
      DIV_C1: begin
        div_a = cap_r;
        div_d = W'(b_eff);
      end
      DIV_C2: begin
        div_a = rem_r;
        div_d = W'(b_eff);
      end
      default: begin
        div_a = n_r;
        div_d = W'(b_eff);
      end
    endcase
  end

  ptbc_div #(.W(W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_d),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  assign div_ceil = div_quo + W'(div_rem != '0);

  ptbc_sqrt #(.W(W)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.sqrt_start),
    .radicand  (q_r),
    .done      (sq_done),
    .root_ceil (sq_root)
  );

  // Shift-and-add multiplier for full * ceil(cap / b); it ends when the
  // multiplier bits run out. The product never exceeds the level's node count.
  assign mul_done = mul_busy_r && (mul_b_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
    end else if (cmd.mul_start) begin
      mul_busy_r <= 1'b1;
    end else if (mul_done) begin
      mul_busy_r <= 1'b0;
    end
    if (cmd.mul_start) begin
      mul_a_r <= (W + 2)'(c1_r);
      mul_b_r <= full_r;
      prod_r  <= '0;
    end else if (mul_busy_r && (mul_b_r != '0)) begin
      if (mul_b_r[0]) begin
        prod_r <= prod_r + mul_a_r;
      end
      mul_a_r <= {mul_a_r[W:0], 1'b0};
      mul_b_r <= {1'b0, mul_b_r[W-1:1]};
    end
  end

  // Level sum, saturation and the no-progress check.
  assign parents = SUM_W'(prod_r) + SUM_W'(c2_r);
  assign sum     = SUM_W'(total_r) + parents;
  assign sat     = (sum > SUM_W'(TOTAL_MAX));

  // Level registers: latch unit results as they complete; load or update n and the total.
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_sel_r <= cmd.div_sel;
    end
    if (div_done) begin
      case (div_sel_r)
        DIV_Q:    q_r   <= div_ceil;
        DIV_CAP:  cap_r <= div_ceil;
        DIV_FULL: begin
          full_r <= div_quo;
          rem_r  <= div_rem;
        end
        DIV_C1:   c1_r  <= div_ceil;
        DIV_C2:   c2_r  <= div_ceil;
        default:  q_r   <= div_ceil;
      endcase
    end
    if (sq_done) begin
      s_r <= sq_root;
    end
    if (cmd.load) begin
      n_r     <= W'(leaf_count);
      total_r <= '0;
    end else if (cmd.acc) begin
      total_r <= sat ? TOTAL_MAX : sum[W:0];
      if (!sat && (parents < SUM_W'(n_r))) begin
        n_r <= parents[W-1:0];
      end
    end
  end

  // Output register holds a finished total until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_data_r <= total_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_total = out_data_r;

  // Status back to the controller.
  always_comb begin
    sts.div_done  = div_done;
    sts.sqrt_done = sq_done;
    sts.mul_done  = mul_done;
    sts.n_gt1     = (n_r > W'(1));
    sts.stop      = sat || (parents >= SUM_W'(n_r));
    sts.out_free  = !out_valid_r || out_ready;
  end

endmodule

/* src/ptbc_ctrl.sv */
// Controller: sequences the per-level divisions, square root, multiply and sum.
`timescale 1ns / 1ps
module ptbc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ptbc_pkg::sts_t sts,
  output ptbc_pkg::cmd_t cmd
);

  import ptbc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:       if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK:      state_nxt = sts.n_gt1 ? ST_Q_START : ST_DONE;
      ST_Q_START:    state_nxt = ST_Q_WAIT;
      ST_Q_WAIT:     if (sts.div_done) state_nxt = ST_SQ_START;
      ST_SQ_START:   state_nxt = ST_SQ_WAIT;
      ST_SQ_WAIT:    if (sts.sqrt_done) state_nxt = ST_CAP_START;
      ST_CAP_START:  state_nxt = ST_CAP_WAIT;
      ST_CAP_WAIT:   if (sts.div_done) state_nxt = ST_FULL_START;
      ST_FULL_START: state_nxt = ST_FULL_WAIT;
      ST_FULL_WAIT:  if (sts.div_done) state_nxt = ST_C1_START;
      ST_C1_START:   state_nxt = ST_C1_WAIT;
      ST_C1_WAIT:    if (sts.div_done) state_nxt = ST_C2_START;
      ST_C2_START:   state_nxt = ST_C2_WAIT;
      ST_C2_WAIT:    if (sts.div_done) state_nxt = ST_MUL_START;
      ST_MUL_START:  state_nxt = ST_MUL_WAIT;
      ST_MUL_WAIT:   if (sts.mul_done) state_nxt = ST_ACC;
      ST_ACC:        state_nxt = sts.stop ? ST_DONE : ST_CHECK;
      ST_DONE:       if (sts.out_free) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd        = '0;
    cmd.div_sel = DIV_Q;
    in_ready   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_Q_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_Q;
      end
      ST_SQ_START:   cmd.sqrt_start = 1'b1;
      ST_CAP_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_CAP;
      end
      ST_FULL_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_FULL;
      end
      ST_C1_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_C1;
      end
      ST_C2_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_C2;
      end
      ST_MUL_START:  cmd.mul_start = 1'b1;
      ST_ACC:        cmd.acc = 1'b1;
      ST_DONE:       cmd.out_load = sts.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* src/packed_tree_branch_count_core.sv */
// Top level of the packed tree branch counter.
`timescale 1ns / 1ps
// Counts the internal nodes that a sort-tile-recursive packed tree builds over
// in_tdata leaves with at most branch_size children per node (values below two
// act as two). One beat in gives one beat out; counts of zero or one give zero,
// and the total saturates at 2^(COUNT_WIDTH+1)-1. Items are handled one at a
// time. Each tree level runs five divisions on a shared one-bit-per-cycle
// divider, a rounded-up square root at two bits per cycle and a shift-and-add
// multiply. A result waits in an output register and the next beat is
// accepted once it has been moved there.
module packed_tree_branch_count_core #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // Configuration: branch_size.
  input  logic                                    cfg_wr_en,
  input  logic [7:0]                              cfg_wr_data,
  // Input stream. tdata: leaf_count[31:0].
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [31:0]                             in_tdata,
  // Result stream. tdata: branch_count[COUNT_WIDTH:0], then zero fill.
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [((COUNT_WIDTH + 1 + 7) / 8) * 8 - 1:0] out_tdata
);

  import ptbc_pkg::*;

  localparam int OUT_W = ((COUNT_WIDTH + 1 + 7) / 8) * 8;

  cmd_t                 cmd;
  sts_t                 sts;
  logic [COUNT_WIDTH:0] total;

  ptbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptbc_dp #(.W(COUNT_WIDTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .leaf_count  (in_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_total   (total)
  );

  assign out_tdata = OUT_W'(total);

endmodule
